// ===== rtl/b64lw_pkg.sv =====
// b64lw_pkg: shared types, constants and the alphabet function of the base64 line-wrap encoder
// no dependencies

package b64lw_pkg;

   localparam int MAX_CHARS  = 5;
   localparam int GROUP_SYMS = 4;
   localparam int CHAR_W     = 7;
   localparam int COUNT_W    = $clog2(MAX_CHARS + 1);

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;
   localparam logic [CHAR_W-1:0] CHAR_PAD     = 7'd61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 7'd43;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 7'd47;

   typedef logic [CHAR_W-1:0] char_type;

   typedef struct packed {
      char_type ch;
      logic     last;
   } slot_type;

   // one encoded group handed to the output queue
   typedef struct packed {
      logic                      valid;
      logic                      newline;
      logic                      last;
      char_type [GROUP_SYMS-1:0] syms;
   } load_type;

   typedef struct packed {
      logic empty;
      logic last_one;
   } queue_status_type;

   function automatic char_type sym(input logic [5:0] v);
      char_type r;
      if (v < 6'd26) begin
         r = CHAR_UPPER_A + {1'b0, v};
      end else if (v < 6'd52) begin
         r = CHAR_LOWER_A + {1'b0, v - 6'd26};
      end else if (v < 6'd62) begin
         r = CHAR_DIGIT_0 + {1'b0, v - 6'd52};
      end else if (v == 6'd62) begin
         r = CHAR_PLUS;
      end else begin
         r = CHAR_SLASH;
      end
      return r;
   endfunction

endpackage

// ===== rtl/b64lw_if.sv =====
// b64lw_req_if, b64lw_rsp_if: valid/ready channels of the base64 line-wrap encoder
// no dependencies

interface b64lw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface b64lw_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_char;

   modport source (output valid, out_char, last_char, input ready);
   modport sink   (input valid, out_char, last_char, output ready);
endinterface

// ===== rtl/b64lw_out_queue.sv =====
// b64lw_out_queue: shift queue that holds one encoded group and sends one char per cycle while popped
// depends on b64lw_pkg

module b64lw_out_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  b64lw_pkg::load_type         load,
   input  logic                        pop,
   output b64lw_pkg::slot_type         head,
   output logic                        head_valid,
   output b64lw_pkg::queue_status_type status
);

   b64lw_pkg::slot_type [b64lw_pkg::MAX_CHARS-1:0] slots_ff, slots_in;
   logic [b64lw_pkg::COUNT_W-1:0]                  cnt_ff, cnt_in;

   always_comb begin
      slots_in = slots_ff;
      cnt_in   = cnt_ff;
      if (load.valid) begin
         slots_in = '0;
         if (load.newline) begin
            slots_in[0].ch   = b64lw_pkg::CHAR_NEWLINE;
            slots_in[0].last = 1'b0;
            for (int i = 0; i < b64lw_pkg::GROUP_SYMS; i++) begin
               slots_in[i+1].ch   = load.syms[i];
               slots_in[i+1].last = 1'b0;
            end
            slots_in[b64lw_pkg::GROUP_SYMS].last = load.last;
            cnt_in = b64lw_pkg::COUNT_W'(b64lw_pkg::GROUP_SYMS + 1);
         end else begin
            for (int i = 0; i < b64lw_pkg::GROUP_SYMS; i++) begin
               slots_in[i].ch   = load.syms[i];
               slots_in[i].last = 1'b0;
            end
            slots_in[b64lw_pkg::GROUP_SYMS-1].last = load.last;
            cnt_in = b64lw_pkg::COUNT_W'(b64lw_pkg::GROUP_SYMS);
         end
      end else if (pop && cnt_ff != '0) begin
         for (int i = 0; i < b64lw_pkg::MAX_CHARS - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
         slots_in[b64lw_pkg::MAX_CHARS-1] = '0;
         cnt_in = cnt_ff - b64lw_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   assign head            = slots_ff[0];
   assign head_valid      = (cnt_ff != '0);
   assign status.empty    = (cnt_ff == '0);
   assign status.last_one = (cnt_ff == b64lw_pkg::COUNT_W'(1));

endmodule

// ===== rtl/base64_encoder_line_wrap_unit.sv =====
// base64_encoder_line_wrap_unit: top level, byte grouping, base64 symbol lookup, line counting
// depends on b64lw_pkg, b64lw_if, b64lw_out_queue
//
//   channel   dir   payload                  handshake
//   req_chan  in    data_byte[7:0], last_byte valid/ready
//   rsp_chan  out   out_char[6:0], last_char  valid/ready
//   csr_*     in    csr_wr_data (line breaks) csr_wr_en
//
// a byte that does not close a group is always taken
// a closing byte is taken once the output queue is empty or sends its last char that cycle
// a group of up to 3 bytes leaves as 4 chars, 5 with a newline, one per cycle while rsp_chan is ready
// synchronous active-high reset clears held bytes, line count, queue and csr
// a stalled rsp_chan holds its char; bytes that do not close a group are still taken

module base64_encoder_line_wrap_unit #(
   parameter int GROUPS_PER_LINE = 19
) (
   input  logic              clock,
   input  logic              reset,
   b64lw_req_if.sink         req_chan,
   b64lw_rsp_if.source       rsp_chan,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int GolW = $clog2(GROUPS_PER_LINE + 1);

   logic [15:0]     held_bytes_ff, held_bytes_in;
   logic [1:0]      held_count_ff, held_count_in;
   logic [GolW-1:0] gol_ff, gol_in;
   logic            line_breaks_ff;

   b64lw_pkg::load_type         load;
   b64lw_pkg::slot_type         head;
   b64lw_pkg::queue_status_type q_status;
   logic                        head_valid;
   logic                        pop;
   logic                        q_free;
   logic                        completes;
   logic                        accept;
   logic                        wrap;
   logic [7:0]                  b0, b1, b2;

   assign pop       = head_valid && rsp_chan.ready;
   assign q_free    = q_status.empty || (q_status.last_one && rsp_chan.ready);
   assign completes = req_chan.last_byte || (held_count_ff >= 2'd2);
   assign req_chan.ready = !completes || q_free;
   assign accept    = req_chan.valid && req_chan.ready;
   assign wrap      = (gol_ff >= GolW'(GROUPS_PER_LINE));

   always_comb begin
      b0 = req_chan.data_byte;
      b1 = 8'd0;
      b2 = 8'd0;
      unique case (held_count_ff)
         2'd0: begin
            b0 = req_chan.data_byte;
         end
         2'd1: begin
            b0 = held_bytes_ff[15:8];
            b1 = req_chan.data_byte;
         end
         default: begin
            b0 = held_bytes_ff[15:8];
            b1 = held_bytes_ff[7:0];
            b2 = req_chan.data_byte;
         end
      endcase
   end

   always_comb begin
      load.valid   = accept && completes;
      load.newline = wrap && line_breaks_ff;
      load.last    = req_chan.last_byte;
      load.syms[0] = b64lw_pkg::sym(b0[7:2]);
      load.syms[1] = b64lw_pkg::sym({b0[1:0], b1[7:4]});
      load.syms[2] = (held_count_ff != 2'd0) ? b64lw_pkg::sym({b1[3:0], b2[7:6]})
                                             : b64lw_pkg::CHAR_PAD;
      load.syms[3] = (held_count_ff >= 2'd2) ? b64lw_pkg::sym(b2[5:0])
                                             : b64lw_pkg::CHAR_PAD;
   end

   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      gol_in        = gol_ff;
      if (accept) begin
         if (completes) begin
            held_bytes_in = '0;
            held_count_in = 2'd0;
            if (req_chan.last_byte) begin
               gol_in = '0;
            end else if (wrap) begin
               gol_in = GolW'(1);
            end else begin
               gol_in = gol_ff + GolW'(1);
            end
         end else if (held_count_ff == 2'd0) begin
            held_bytes_in = {req_chan.data_byte, 8'd0};
            held_count_in = 2'd1;
         end else begin
            held_bytes_in = {held_bytes_ff[15:8], req_chan.data_byte};
            held_count_in = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff  <= '0;
         held_count_ff  <= 2'd0;
         gol_ff         <= '0;
         line_breaks_ff <= 1'b0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
         gol_ff        <= gol_in;
         if (csr_wr_en) begin
            line_breaks_ff <= csr_wr_data;
         end
      end
   end

   b64lw_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .status     (q_status)
   );

   assign rsp_chan.valid     = head_valid;
   assign rsp_chan.out_char  = head.ch;
   assign rsp_chan.last_char = head.last;

endmodule

// ===== rtl/b64lw_checker.sv =====
// b64lw_checker: port-level assertions for base64_encoder_line_wrap_unit, bound to the top level
// depends on b64lw_pkg and base64_encoder_line_wrap_unit

module b64lw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_out_char,
   input logic       rsp_last_char
);

   // newline never ends a message
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_char == b64lw_pkg::CHAR_NEWLINE |-> !rsp_last_char)
      else $error("newline flagged as last char");

   // closing byte of a message shows output on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid)
      else $error("no output after last byte");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("stalled output changed");

endmodule

bind base64_encoder_line_wrap_unit b64lw_checker u_b64lw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_last_byte (req_chan.last_byte),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_char  (rsp_chan.out_char),
   .rsp_last_char (rsp_chan.last_char)
);
